>>> sv/mdat_pkg.sv
// ----------------------------------------------------------------------------
// mdat_pkg
// Shared types and constants for the five-pin debounce and axis tracker.
// ----------------------------------------------------------------------------
package mdat_pkg;

	localparam int unsigned NUM_PINS  = 5;
	localparam int unsigned LEN_W     = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned POS_OUT_W = 16;

	// pin slots, also the configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_TACHO   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TRIGGER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOME    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BUTTON  = 3'd4;

	localparam int unsigned PIN_TACHO   = 0;
	localparam int unsigned PIN_TRIGGER = 1;
	localparam int unsigned PIN_HOME    = 2;
	localparam int unsigned PIN_LIMIT   = 3;
	localparam int unsigned PIN_BUTTON  = 4;

	// reset lengths
	localparam logic [LEN_W-1:0] TACHO_LEN_RST = 8'd3;
	localparam logic [LEN_W-1:0] OTHER_LEN_RST = 8'd10;

	// confirmed edge of one debounce channel
	typedef struct packed {
		logic rise;
		logic fall;
	} edge_t;

endpackage

>>> sv/mdat_debounce.sv
// ----------------------------------------------------------------------------
// mdat_debounce
// One pin's leading and trailing debounce counters with edge detect.
// ----------------------------------------------------------------------------
module mdat_debounce import mdat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin,
	input  logic [LEN_W-1:0] len,
	output edge_t            edge_det
);

	logic [LEN_W-1:0] lead_q;
	logic [LEN_W-1:0] trail_q;
	logic [LEN_W-1:0] lead_d;
	logic [LEN_W-1:0] trail_d;
	logic [LEN_W-1:0] lead_dec;
	logic [LEN_W-1:0] trail_dec;

	assign lead_dec  = lead_q - LEN_W'(1);
	assign trail_dec = trail_q - LEN_W'(1);

	always_comb begin
		lead_d        = lead_q;
		trail_d       = trail_q;
		edge_det.rise = 1'b0;
		edge_det.fall = 1'b0;
		if (pin) begin
			if (lead_q == '0) begin
				trail_d = len;
			end else begin
				lead_d = lead_dec;
				if (lead_dec == '0) begin
					trail_d       = len;
					edge_det.rise = 1'b1;
				end
			end
		end else begin
			if (trail_q == '0) begin
				lead_d = len;
			end else begin
				trail_d = trail_dec;
				if (trail_dec == '0) begin
					lead_d        = len;
					edge_det.fall = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			trail_q <= '0;
		end else if (step) begin
			lead_q  <= lead_d;
			trail_q <= trail_d;
		end
	end

endmodule

>>> sv/multi_input_debounce_axis_tracker_core.sv
// ----------------------------------------------------------------------------
// multi_input_debounce_axis_tracker_core
// Each accepted transaction is one sample tick of five raw pins (tacho,
// trigger, home, limit, button). Every pin runs a leading and a trailing
// debounce counter reloaded from its length register; a counter that hits
// zero confirms an edge. Tacho edges move the axis position up (wrapping) or
// down (held at zero) unless power is settling; a home release with the motor
// on clears position and limit error, a limit hit sets the error. The block
// is a two-register pipeline: the input register holds the tick, one level of
// logic updates all state and fills the result register. It takes one
// transaction per cycle unless out_ready stalls it; the result register lets
// the next tick enter while a result waits. The user must write length
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module multi_input_debounce_axis_tracker_core import mdat_pkg::*; #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_wdata,
	// input tick
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 pin_tacho,
	input  logic                 pin_trigger,
	input  logic                 pin_home,
	input  logic                 pin_limit,
	input  logic                 pin_button,
	input  logic                 direction,
	input  logic                 settling,
	input  logic                 motor_on,
	input  logic                 axis_busy,
	input  logic                 readdr_active,
	// result
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NUM_PINS-1:0]  levels,
	output logic [POS_OUT_W-1:0] axis_position,
	output logic                 tacho_edge,
	output logic                 event_tacho,
	output logic                 event_home,
	output logic                 event_zeroed,
	output logic                 event_limit,
	output logic                 event_button,
	output logic                 event_stop,
	output logic                 limit_error
);

	// length registers
	logic [LEN_W-1:0] len_q [NUM_PINS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[PIN_TACHO]   <= TACHO_LEN_RST;
			len_q[PIN_TRIGGER] <= OTHER_LEN_RST;
			len_q[PIN_HOME]    <= OTHER_LEN_RST;
			len_q[PIN_LIMIT]   <= OTHER_LEN_RST;
			len_q[PIN_BUTTON]  <= OTHER_LEN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TACHO:   len_q[PIN_TACHO]   <= cfg_wdata;
				REG_TRIGGER: len_q[PIN_TRIGGER] <= cfg_wdata;
				REG_HOME:    len_q[PIN_HOME]    <= cfg_wdata;
				REG_LIMIT:   len_q[PIN_LIMIT]   <= cfg_wdata;
				REG_BUTTON:  len_q[PIN_BUTTON]  <= cfg_wdata;
				default:     ; // unknown index, write dropped
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drained
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;

	assign adv_s1    = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv_s1;
	assign out_valid = valid_s2;

	// input register
	logic [NUM_PINS-1:0] pins_s1;
	logic                direction_s1;
	logic                settling_s1;
	logic                motor_on_s1;
	logic                axis_busy_s1;
	logic                readdr_active_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pins_s1          <= {pin_button, pin_limit, pin_home, pin_trigger, pin_tacho};
			direction_s1     <= direction;
			settling_s1      <= settling;
			motor_on_s1      <= motor_on;
			axis_busy_s1     <= axis_busy;
			readdr_active_s1 <= readdr_active;
		end
	end

	// state advances once per tick, when the tick leaves stage 1
	logic step;
	assign step = valid_s1 && adv_s1;

	// debounce channels
	edge_t edges [NUM_PINS];

	for (genvar k = 0; k < NUM_PINS; k++) begin : g_pin
		mdat_debounce u_deb (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (step),
			.pin      (pins_s1[k]),
			.len      (len_q[k]),
			.edge_det (edges[k])
		);
	end

	// debounced levels; button level reads as pressed, so its sense is flipped
	logic [NUM_PINS-1:0] lvl_q;
	logic [NUM_PINS-1:0] lvl_d;

	always_comb begin
		lvl_d = lvl_q;
		for (int k = 0; k < NUM_PINS; k++) begin
			if (edges[k].rise) begin
				lvl_d[k] = (k != PIN_BUTTON);
			end else if (edges[k].fall) begin
				lvl_d[k] = (k == PIN_BUTTON);
			end
		end
	end

	// event decode
	logic t_edge;
	logic ev_tacho;
	logic ev_home;
	logic ev_zero;
	logic ev_limit;
	logic ev_button;
	logic ev_stop;
	logic do_zero;

	assign t_edge    = edges[PIN_TACHO].rise || edges[PIN_TACHO].fall;
	assign ev_tacho  = t_edge && !settling_s1;
	assign ev_home   = edges[PIN_HOME].rise;
	assign ev_zero   = edges[PIN_HOME].fall;
	assign ev_limit  = edges[PIN_LIMIT].rise;
	// button press is the trailing edge of the raw (active low) pin
	assign ev_stop   = edges[PIN_BUTTON].fall && axis_busy_s1;
	assign ev_button = edges[PIN_BUTTON].fall && !axis_busy_s1 && !readdr_active_s1;
	assign do_zero   = ev_zero && motor_on_s1;

	// position: up wraps, down holds at zero, zeroing wins over the tacho step
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_d;
	logic                     err_q;
	logic                     err_d;

	always_comb begin
		pos_d = pos_q;
		if (ev_tacho) begin
			if (direction_s1) begin
				pos_d = pos_q + POSITION_BITS'(1);
			end else if (pos_q != '0) begin
				pos_d = pos_q - POSITION_BITS'(1);
			end
		end
		if (do_zero) begin
			pos_d = '0;
		end
	end

	// limit hit in the same tick sets the flag after zeroing cleared it
	always_comb begin
		err_d = err_q;
		if (do_zero) begin
			err_d = 1'b0;
		end
		if (ev_limit) begin
			err_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			pos_q <= '0;
			err_q <= 1'b0;
		end else if (step) begin
			lvl_q <= lvl_d;
			pos_q <= pos_d;
			err_q <= err_d;
		end
	end

	// low bits of the position for the result port
	logic [POS_OUT_W-1:0] pos_out;

	if (POSITION_BITS >= POS_OUT_W) begin : g_pos_trunc
		assign pos_out = pos_d[POS_OUT_W-1:0];
	end else begin : g_pos_ext
		assign pos_out = {{(POS_OUT_W-POSITION_BITS){1'b0}}, pos_d};
	end

	// result register
	logic [NUM_PINS-1:0]  levels_s2;
	logic [POS_OUT_W-1:0] pos_s2;
	logic                 t_edge_s2;
	logic                 ev_tacho_s2;
	logic                 ev_home_s2;
	logic                 ev_zero_s2;
	logic                 ev_limit_s2;
	logic                 ev_button_s2;
	logic                 ev_stop_s2;
	logic                 err_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			levels_s2    <= lvl_d;
			pos_s2       <= pos_out;
			t_edge_s2    <= t_edge;
			ev_tacho_s2  <= ev_tacho;
			ev_home_s2   <= ev_home;
			ev_zero_s2   <= ev_zero;
			ev_limit_s2  <= ev_limit;
			ev_button_s2 <= ev_button;
			ev_stop_s2   <= ev_stop;
			err_s2       <= err_d;
		end
	end

	assign levels        = levels_s2;
	assign axis_position = pos_s2;
	assign tacho_edge    = t_edge_s2;
	assign event_tacho   = ev_tacho_s2;
	assign event_home    = ev_home_s2;
	assign event_zeroed  = ev_zero_s2;
	assign event_limit   = ev_limit_s2;
	assign event_button  = ev_button_s2;
	assign event_stop    = ev_stop_s2;
	assign limit_error   = err_s2;

`ifndef SYNTHESIS
	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// a press is either a start or a stop, never both
	a_button_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(event_button && event_stop))
		else $error("button and stop events together");

	// counted tacho event needs a confirmed edge
	a_tacho_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_tacho |-> tacho_edge)
		else $error("tacho event without tacho edge");

	// a limit hit always leaves the error flag set
	a_limit_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_limit |-> limit_error)
		else $error("limit event without error flag");
`endif

endmodule
